// ----- design/ffha_pkg.sv -----
//------------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
//------------------------------------------------------------------------------
package ffha_pkg;
  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ALLOC   = 2'd0;
  localparam kind_t KIND_RELEASE = 2'd1;
  localparam kind_t KIND_REINIT  = 2'd2;
  localparam kind_t KIND_IGNORED = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_ZERO    = 2'd2;
  localparam status_t ST_UNKNOWN = 2'd3;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [31:0] RESET_BASE  = 32'h0010_0000;
  localparam logic [31:0] RESET_LIMIT = 32'h0020_0000;

  // Input item: kind, request size, release address.
  typedef struct packed {
    logic [31:0] release_address;
    logic [31:0] request_size;
    kind_t       kind;
  } req_t;

  typedef struct packed {
    logic [31:0] avail_bytes;
    logic [31:0] used_bytes;
    logic [31:0] payload_address;
    status_t     status;
  } rsp_t;

  function automatic logic [31:0] span_size(input logic [31:0] base, input logic [31:0] lim);
    logic [32:0] span;
    begin
      span = {1'b0, lim} - {1'b0, base};
      if (lim < base || span < 33'(HEADER_BYTES)) span_size = '0;
      else span_size = 32'(span - 33'(HEADER_BYTES));
    end
  endfunction
endpackage

// ----- design/ffha_table.sv -----
//------------------------------------------------------------------------------
// ffha_table
// Segment table memory: one write port and one registered read port.
//------------------------------------------------------------------------------
module ffha_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ffha_pkg::IDX_W-1:0] waddr,
  input  logic [32:0]              wdata,
  input  logic [ffha_pkg::IDX_W-1:0] raddr,
  output logic [32:0]              rdata
);
  import ffha_pkg::*;
  // Bit 32 is the free mark, bits 31:0 the payload size.
  logic [32:0] mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Allocate walks the table to the fit and shifts the tail when splitting,
// release walks to the segment and then compacts in one merge pass, and every item
// ends with a summing pass over the segments; out_tready can stall the result.
// Throughput is one item at a time; the table's single read port sets the pace.
// Synchronous active-low rst_n restores state, base, limit, count and one free segment.
//------------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list heap allocator over an address-ordered segment table.
//------------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // kind[1:0], request_size[33:2], release_address[65:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [103:0] out_tdata, // status[1:0], payload_address[33:2],
                                  // used_bytes[65:34], avail_bytes[97:66]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND, S_SHIFT_RD, S_SHIFT, S_MERGE_RD, S_MERGE,
    S_SUM_RD, S_SUM, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        base_r, limit_r;
  req_t               req_r;
  rsp_t               rsp_r, rsp_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;  // scan index
  logic [CNT_W-1:0]   j_r, j_nxt;  // write index for shift / compaction
  logic [31:0]        addr_r, addr_nxt;
  logic [32:0]        need_r;
  logic [32:0]        acc_r, acc_nxt; // merged entry being built
  logic               acc_v_r, acc_v_nxt;
  logic [32:0]        carry_r, carry_nxt; // entry displaced during shift
  logic [31:0]        used_r, used_nxt, free_r, free_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [32:0]        wdata, rdata;
  logic               we_q;
  logic [IDX_W-1:0]   waddr_q;
  logic [32:0]        wdata_q;

  ffha_table u_tab (
    .clk, .we(we_q), .waddr(waddr_q), .wdata(wdata_q), .raddr, .rdata
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, rsp_r};
  assign cfg_ready  = (state_r == S_IDLE);

  logic [31:0] seg_sz;
  logic        seg_fr;
  logic [33:0] seg_need;
  assign seg_sz = rdata[31:0];
  assign seg_fr = rdata[32];
  assign seg_need = {1'b0, need_r} + 34'(HEADER_BYTES + 4);

  always_comb begin
    state_nxt = state_r; rsp_nxt = rsp_r; count_nxt = count_r;
    i_nxt = i_r; j_nxt = j_r; addr_nxt = addr_r; acc_nxt = acc_r; acc_v_nxt = acc_v_r;
    carry_nxt = carry_r; used_nxt = used_r; free_nxt = free_r;
    we = 1'b0; waddr = i_r[IDX_W-1:0]; wdata = '0; raddr = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rsp_nxt = '0;
          i_nxt = '0; addr_nxt = base_r;
          raddr = '0;
          case (in_tdata[1:0])
            KIND_ALLOC: begin
              if (in_tdata[33:2] == '0) begin
                rsp_nxt.status = ST_ZERO; state_nxt = S_SUM_RD;
              end else state_nxt = S_FIND_RD;
            end
            KIND_RELEASE: begin
              if (in_tdata[65:34] == '0) state_nxt = S_SUM_RD;
              else state_nxt = S_FIND_RD;
            end
            KIND_REINIT: begin
              we = 1'b1; waddr = '0;
              wdata = {1'b1, span_size(base_r, limit_r)};
              count_nxt = CNT_W'(1); state_nxt = S_SUM_RD;
            end
            default: state_nxt = S_SUM_RD;
          endcase
        end
      end
      S_FIND_RD: state_nxt = S_FIND;  // read of entry i in flight
      S_FIND: begin
        if (i_r >= count_r) begin
          rsp_nxt.status = (req_r.kind == KIND_ALLOC) ? ST_NOFIT : ST_UNKNOWN;
          i_nxt = '0; state_nxt = S_SUM_RD;
        end else if (req_r.kind == KIND_ALLOC) begin
          if (seg_fr && {1'b0, seg_sz} >= need_r) begin
            rsp_nxt.payload_address = addr_r + 32'(HEADER_BYTES);
            we = 1'b1;
            if ({2'b0, seg_sz} >= seg_need && count_r < CNT_W'(MAX_SEGMENTS)) begin
              wdata = {1'b0, need_r[31:0]};
              carry_nxt = {1'b1, 32'(34'(seg_sz) - 34'(need_r) - 34'(HEADER_BYTES))};
              j_nxt = i_r + CNT_W'(1);
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_SHIFT_RD;
              raddr = (i_r + CNT_W'(1)) >= CNT_W'(MAX_SEGMENTS) ? '0 :
                      IDX_W'(i_r + CNT_W'(1));
            end else begin
              wdata = {1'b0, seg_sz};
              i_nxt = '0; state_nxt = S_SUM_RD;
            end
          end else begin
            addr_nxt = addr_r + 32'(HEADER_BYTES) + seg_sz;
            i_nxt = i_r + CNT_W'(1); raddr = IDX_W'(i_r + CNT_W'(1));
            state_nxt = S_FIND;
          end
        end else begin
          if (addr_r + 32'(HEADER_BYTES) == req_r.release_address) begin
            we = 1'b1; wdata = {1'b1, seg_sz};
            i_nxt = '0; j_nxt = '0; acc_v_nxt = 1'b0;
            state_nxt = S_MERGE_RD;
          end else begin
            addr_nxt = addr_r + 32'(HEADER_BYTES) + seg_sz;
            i_nxt = i_r + CNT_W'(1); raddr = IDX_W'(i_r + CNT_W'(1));
            state_nxt = S_FIND;
          end
        end
      end
      // Insert carry at j, pushing the old entries one place up.
      S_SHIFT_RD: begin raddr = IDX_W'(j_r); state_nxt = S_SHIFT; end
      S_SHIFT: begin
        we = 1'b1; waddr = IDX_W'(j_r); wdata = carry_r;
        carry_nxt = rdata;
        if (j_r + CNT_W'(1) >= count_r) begin
          i_nxt = '0; state_nxt = S_SUM_RD;
        end else begin
          j_nxt = j_r + CNT_W'(1); state_nxt = S_SHIFT_RD;
        end
      end
      // Compaction: read i, fold free runs into acc, write out at j.
      S_MERGE_RD: begin raddr = IDX_W'(i_r); state_nxt = S_MERGE; end
      S_MERGE: begin
        if (i_r >= count_r) begin
          we = 1'b1; waddr = IDX_W'(j_r); wdata = acc_r;
          count_nxt = j_r + CNT_W'(1);
          i_nxt = '0; state_nxt = S_SUM_RD;
        end else begin
          if (acc_v_r && acc_r[32] && seg_fr) begin
            acc_nxt = {1'b1, acc_r[31:0] + 32'(HEADER_BYTES) + seg_sz};
          end else begin
            if (acc_v_r) begin
              we = 1'b1; waddr = IDX_W'(j_r); wdata = acc_r;
              j_nxt = j_r + CNT_W'(1);
            end
            acc_nxt = rdata;
          end
          acc_v_nxt = 1'b1;
          i_nxt = i_r + CNT_W'(1); state_nxt = S_MERGE_RD;
        end
      end
      S_SUM_RD: begin
        raddr = IDX_W'(i_r); used_nxt = (i_r == '0) ? '0 : used_r;
        free_nxt = (i_r == '0) ? '0 : free_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (seg_fr) free_nxt = free_r + seg_sz;
        else used_nxt = used_r + 32'(HEADER_BYTES) + seg_sz;
        if (i_r + CNT_W'(1) >= count_r) begin
          rsp_nxt.used_bytes = seg_fr ? used_r : used_r + 32'(HEADER_BYTES) + seg_sz;
          rsp_nxt.avail_bytes = seg_fr ? free_r + seg_sz : free_r;
          state_nxt = S_OUT;
        end else begin
          i_nxt = i_r + CNT_W'(1); state_nxt = S_SUM_RD;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; base_r <= RESET_BASE; limit_r <= RESET_LIMIT;
      count_r <= CNT_W'(1);
    end else begin
      state_r <= state_nxt; count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        else limit_r <= cfg_data;
      end
    end
    if (in_tvalid && in_tready) begin
      req_r <= in_tdata[65:0];
      need_r <= ({1'b0, in_tdata[33:2]} + 33'd3) & ~33'd3;
    end
    rsp_r <= rsp_nxt; i_r <= i_nxt; j_r <= j_nxt; addr_r <= addr_nxt;
    acc_r <= acc_nxt; acc_v_r <= acc_v_nxt; carry_r <= carry_nxt;
    used_r <= used_nxt; free_r <= free_nxt;
  end

  // Entry zero is loaded with the single free segment while reset is held.
  always_comb begin
    we_q = we; waddr_q = waddr; wdata_q = wdata;
    if (!rst_n) begin
      we_q = 1'b1; waddr_q = '0; wdata_q = {1'b1, span_size(RESET_BASE, RESET_LIMIT)};
    end
  end
endmodule

// ----- tb/ffha_checker.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ffha_checker
// Watches the request, result and register channels of the heap allocator,
// keeps its own segment table, and compares every result item with the
// expected one in order.
//------------------------------------------------------------------------------
module ffha_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           pending,
  output int           fail_count
);
  import ffha_pkg::*;

  logic [31:0] base_q, limit_q;
  logic [31:0] seg_len [MAX_SEGMENTS];
  logic        seg_avail [MAX_SEGMENTS];
  int unsigned seg_n;
  rsp_t        rsp_queue [$];

  initial fail_count = 0;
  assign pending = rsp_queue.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] span_len(input logic [31:0] b, input logic [31:0] l);
    logic [32:0] s;
    s = {1'b0, l} - {1'b0, b};
    if (l < b || s < 33'(HEADER_BYTES)) return '0;
    return 32'(s - 33'(HEADER_BYTES));
  endfunction

  function automatic void rebuild();
    seg_len[0] = span_len(base_q, limit_q);
    seg_avail[0] = 1'b1;
    seg_n = 1;
  endfunction

  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < seg_n) begin
      if (seg_avail[i] && seg_avail[i+1]) begin
        seg_len[i] = seg_len[i] + HEADER_BYTES + seg_len[i+1];
        for (int unsigned j = i + 1; j + 1 < seg_n; j++) begin
          seg_len[j] = seg_len[j+1];
          seg_avail[j] = seg_avail[j+1];
        end
        seg_n--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic rsp_t heap_step(input req_t rq);
    rsp_t r;
    logic [33:0] need;
    logic [31:0] addr;
    bit done;
    r = '0;
    addr = base_q;
    done = 0;
    case (rq.kind)
      KIND_ALLOC: begin
        if (rq.request_size == 0) begin
          r.status = ST_ZERO;
        end else begin
          need = ({2'b0, rq.request_size} + 34'd3) & ~34'd3;
          for (int unsigned i = 0; i < seg_n && !done; i++) begin
            if (seg_avail[i] && {2'b0, seg_len[i]} >= need) begin
              if ({2'b0, seg_len[i]} >= need + HEADER_BYTES + 4 && seg_n < MAX_SEGMENTS) begin
                for (int unsigned j = seg_n; j > i + 1; j--) begin
                  seg_len[j] = seg_len[j-1];
                  seg_avail[j] = seg_avail[j-1];
                end
                seg_len[i+1] = 32'({2'b0, seg_len[i]} - need - HEADER_BYTES);
                seg_avail[i+1] = 1'b1;
                seg_len[i] = 32'(need);
                seg_n++;
              end
              seg_avail[i] = 1'b0;
              r.status = ST_OK;
              r.payload_address = addr + HEADER_BYTES;
              done = 1;
            end else begin
              addr = addr + HEADER_BYTES + seg_len[i];
            end
          end
          if (!done) r.status = ST_NOFIT;
        end
      end
      KIND_RELEASE: begin
        if (rq.release_address != 0) begin
          r.status = ST_UNKNOWN;
          for (int unsigned i = 0; i < seg_n && !done; i++) begin
            if (addr + HEADER_BYTES == rq.release_address) begin
              seg_avail[i] = 1'b1;
              coalesce();
              r.status = ST_OK;
              done = 1;
            end
            addr = addr + HEADER_BYTES + seg_len[i];
          end
        end
      end
      KIND_REINIT: rebuild();
      default: ;
    endcase
    for (int unsigned i = 0; i < seg_n; i++) begin
      if (seg_avail[i]) r.avail_bytes = r.avail_bytes + seg_len[i];
      else r.used_bytes = r.used_bytes + HEADER_BYTES + seg_len[i];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst_n) begin
      base_q = RESET_BASE;
      limit_q = RESET_LIMIT;
      rebuild();
      rsp_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) base_q = cfg_data;
        else limit_q = cfg_data;
      end
      if (in_tvalid && in_tready) rsp_queue.push_back(heap_step(req_t'(in_tdata[65:0])));
      if (out_tvalid && out_tready) begin
        got = rsp_t'(out_tdata[97:0]);
        if (rsp_queue.size() == 0) begin
          report("unexpected result", got.payload_address, '0);
        end else begin
          want = rsp_queue.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.payload_address != want.payload_address)
            report("payload_address", got.payload_address, want.payload_address);
          if (got.used_bytes != want.used_bytes)
            report("used_bytes", got.used_bytes, want.used_bytes);
          if (got.avail_bytes != want.avail_bytes)
            report("avail_bytes", got.avail_bytes, want.avail_bytes);
        end
      end
    end
  end
endmodule

// ----- tb/tb_first_fit_heap_allocator.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives allocate, release, reinit and ignored items with random gaps on both sides,
// walks several heap settings, and lets the checker judge every result.
//------------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [71:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [103:0] out_tdata;
  logic         cfg_valid, cfg_ready;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           pending, fail_count;
  int           idle_cycles;
  logic [31:0]  live_addr [$];
  logic [31:0]  cur_base;

  first_fit_heap_allocator DUT (.*);

  ffha_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side stalls at random, with calm stretches.
  initial begin
    int g;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      g = gap_len();
      if ($urandom_range(0, 2) != 0 && g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Addresses handed out by successful allocations become release candidates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[1:0] == ST_OK &&
        out_tdata[33:2] != '0) live_addr.push_back(out_tdata[33:2]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_first_fit_heap_allocator: done, errors");
      $finish;
    end
  end

  task automatic send(input kind_t k, input logic [31:0] sz, input logic [31:0] addr);
    req_t rq;
    repeat (gap_len() + 1) @(posedge clk);
    rq.kind = k;
    rq.request_size = sz;
    rq.release_address = addr;
    in_tvalid <= 1;
    in_tdata <= {6'd0, rq};
    @(posedge clk iff in_tready);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_heap(input logic [31:0] b, input logic [31:0] l);
    drain();
    write_reg(CFG_BASE, b);
    write_reg(CFG_LIMIT, l);
    cur_base = b;
    live_addr.delete();
    send(KIND_REINIT, $urandom, $urandom);
  endtask

  // Mostly well-formed traffic: small allocations and releases of live blocks.
  task automatic random_traffic(input int n);
    int r, k;
    logic [31:0] sz;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        sz = (r < 3) ? $urandom : $urandom_range(1, 200);
        send(KIND_ALLOC, sz, $urandom);
      end else if (r < 85 && live_addr.size() > 0) begin
        k = $urandom_range(0, live_addr.size() - 1);
        send(KIND_RELEASE, $urandom, live_addr[k]);
        live_addr.delete(k);
      end else if (r < 93) begin
        a = (r < 89) ? cur_base + HEADER_BYTES + 4 * $urandom_range(0, 600) : $urandom;
        send(KIND_RELEASE, $urandom, a);
      end else if (r < 97) begin
        send(KIND_ALLOC, 0, $urandom);
      end else if (r < 98) begin
        send(KIND_REINIT, $urandom, $urandom);
      end else begin
        send(KIND_IGNORED, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    cur_base = RESET_BASE;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, null and unknown releases, oversized, zero, kind 3.
    send(KIND_ALLOC, 1, 0);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 0);
    send(KIND_ALLOC, 32'hFFFF_FFFD, 0);
    send(KIND_ALLOC, 0, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 13, 0);
    send(KIND_RELEASE, 0, 0);
    send(KIND_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_RELEASE, 0, RESET_BASE + HEADER_BYTES);
    send(KIND_RELEASE, 0, RESET_BASE + HEADER_BYTES);
    send(KIND_RELEASE, 0, RESET_BASE + 2 * HEADER_BYTES + 4);
    send(KIND_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 32'h000F_FFF4, 0);
    send(KIND_REINIT, 0, 0);
    // Fill the table so splitting is suppressed.
    for (int i = 0; i < 66; i++) send(KIND_ALLOC, 4, 0);
    send(KIND_ALLOC, 100, 0);

    // The sender holds off until every result is in.
    drain();
    random_traffic(200);

    set_heap(32'hFFFF_FF00, 32'h0000_0100);    // limit below base: empty heap
    send(KIND_ALLOC, 4, 0);
    set_heap(32'h1000, 32'h100B);              // span below one header
    send(KIND_ALLOC, 4, 0);
    set_heap(32'h1000, 32'h1100);              // small heap, tight fits
    random_traffic(150);
    set_heap(32'hFFFF_FFF0, 32'hFFFF_FFFF);    // top of the address space
    random_traffic(40);
    set_heap(32'h0, 32'hFFFF_FFFF);            // widest heap
    random_traffic(150);
    set_heap(RESET_BASE, RESET_LIMIT);
    random_traffic(150);

    drain();
    if (fail_count == 0) $display("tb_first_fit_heap_allocator: done, clean");
    else $display("tb_first_fit_heap_allocator: done, errors");
    $finish;
  end
endmodule
